// ----- rtl/cmc_pkg.sv -----
package cmc_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_MAP_QUALITY   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BASE_QUALITY  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_COVERAGE      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COVERAGE      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_CHG_SITES    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_CHH_SITES    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHROMOSOME_LENGTH = 3'd6;

	// Input commands
	localparam logic CMD_BASE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Read base codes (nt16)
	localparam logic [3:0] NT16_C = 4'd2;
	localparam logic [3:0] NT16_T = 4'd8;

	// Flags that drop a read: secondary, qc fail, duplicate, supplementary
	localparam logic [11:0] FLAG_DROP_MASK = 12'hF00;

	// Cytosine contexts
	localparam logic [1:0] CTX_NONE = 2'd0;
	localparam logic [1:0] CTX_CPG  = 2'd1;
	localparam logic [1:0] CTX_CHG  = 2'd2;
	localparam logic [1:0] CTX_CHH  = 2'd3;

	// Trinucleotide code for NNN at the reference edges
	localparam logic [7:0] TNC_EDGE = 8'd36;

	// ASCII characters
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'd32;

	// Nucleotide codes
	localparam logic [2:0] NUC_A     = 3'd0;
	localparam logic [2:0] NUC_C     = 3'd1;
	localparam logic [2:0] NUC_G     = 3'd2;
	localparam logic [2:0] NUC_T     = 3'd3;
	localparam logic [2:0] NUC_OTHER = 3'd4;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic        command;
		logic [31:0] ref_pos;
		logic [3:0]  read_base;
		logic [7:0]  base_quality;
		logic [7:0]  map_quality;
		logic [11:0] read_flags;
		logic [7:0]  ref_before;
		logic [7:0]  ref_here;
		logic [7:0]  ref_after;
	} item_t;

	typedef struct packed {
		logic [7:0]  min_map_quality;
		logic [7:0]  min_base_quality;
		logic [15:0] min_coverage;
		logic [15:0] max_coverage;
		logic        keep_chg_sites;
		logic        keep_chh_sites;
		logic [31:0] chromosome_length;
	} cfg_t;

	typedef struct packed {
		logic       keep;
		logic [1:0] ctx;
		logic [7:0] tnc;
	} verdict_t;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
	endfunction

	function automatic logic [2:0] nuc_code(input logic [7:0] c);
		logic [2:0] code;
		case (c)
			CH_A:    code = NUC_A;
			CH_C:    code = NUC_C;
			CH_G:    code = NUC_G;
			CH_T:    code = NUC_T;
			default: code = NUC_OTHER;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/cmc_filter.sv -----
module cmc_filter import cmc_pkg::*; (
	input  item_t       item,
	input  cfg_t        cfg,
	input  logic [31:0] floor_pos,
	output verdict_t    verdict
);

	logic [7:0]  c0, c1, c2;
	logic [2:0]  n0, n1, n2;
	logic        at_edge;
	logic        prev_cat, prev_catn, next_act;
	logic        read_ok;
	logic [1:0]  ctx;
	logic [7:0]  tnc;
	logic        is_cyt;

	// Upper-case the reference characters and map them to codes
	assign c0 = upcase(item.ref_before);
	assign c1 = upcase(item.ref_here);
	assign c2 = upcase(item.ref_after);
	assign n0 = nuc_code(c0);
	assign n1 = nuc_code(c1);
	assign n2 = nuc_code(c2);

	// Edge positions: first base, or next base at or past the reference end
	assign at_edge = (item.ref_pos == 32'd0) ||
		(({1'b0, item.ref_pos} + 33'd1) >= {1'b0, cfg.chromosome_length});

	// Read-level and base-level filters in order
	assign read_ok = ((item.read_flags & FLAG_DROP_MASK) == 12'd0) &&
		(item.map_quality >= cfg.min_map_quality) &&
		(item.ref_pos >= floor_pos) &&
		(item.base_quality >= cfg.min_base_quality);

	assign prev_cat  = (c0 == CH_C) || (c0 == CH_A) || (c0 == CH_T);
	assign prev_catn = prev_cat || (c0 == CH_N);
	assign next_act  = (c2 == CH_A) || (c2 == CH_C) || (c2 == CH_T);

	// Classify the context
	always_comb begin
		if (at_edge) begin
			ctx    = CTX_CHH;
			tnc    = TNC_EDGE;
			is_cyt = 1'b1;
		end else begin
			tnc    = {n0[1:0], n1, n2};
			is_cyt = (c1 == CH_C);
			if (c2 == CH_G) begin
				ctx = CTX_CPG;
			end else if (next_act) begin
				ctx = prev_cat ? CTX_CHH : CTX_CHG;
			end else begin
				ctx = prev_catn ? CTX_CHH : CTX_CHG;
			end
		end
	end

	// Keep filtered cytosines at CpG always, at CHG and CHH when enabled
	always_comb begin
		verdict.ctx = ctx;
		verdict.tnc = tnc;
		case (ctx)
			CTX_CPG: verdict.keep = read_ok && is_cyt;
			CTX_CHG: verdict.keep = read_ok && is_cyt && cfg.keep_chg_sites;
			default: verdict.keep = read_ok && is_cyt && cfg.keep_chh_sites;
		endcase
	end

endmodule

// ----- rtl/cytosine_methylation_counter_top.sv -----
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid / in_stall       command, ref_pos, read_base, qualities,
//                                               read_flags, ref_before/here/after
// out      source     out_valid / out_stall     site_position, counts, site_context,
//                                               trinucleotide_code
// cfg      sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item a cycle unless the result is stalled: an item waits in the input register, where
// filtering, site tracking and counting resolve into the result register.
// The site state loop (open position, counters, last position) updates from its own registers.
// Reset clears the site state and loads the register defaults; cfg_ready is always high.
// A stalled result holds the input register; the input stalls only when it is full.
module cytosine_methylation_counter_top import cmc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [31:0]            ref_pos,
	input  logic [3:0]             read_base,
	input  logic [7:0]             base_quality,
	input  logic [7:0]             map_quality,
	input  logic [11:0]            read_flags,
	input  logic [7:0]             ref_before,
	input  logic [7:0]             ref_here,
	input  logic [7:0]             ref_after,
	// result items
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [31:0]            site_position,
	output logic [15:0]            methylated_count,
	output logic [15:0]            unmethylated_count,
	output logic [1:0]             site_context,
	output logic [7:0]             trinucleotide_code,
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	cfg_t        cfg_q;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	verdict_t    verdict;

	logic [31:0] site_q;
	logic [15:0] meth_q;
	logic [15:0] unmeth_q;
	logic [1:0]  ctx_q;
	logic [7:0]  tnc_q;
	logic [31:0] floor_pos_q;

	logic [31:0] site_new;
	logic        opens;
	logic [16:0] total;
	logic        cov_ok;
	logic        emit;
	logic [15:0] meth_base, unmeth_base;
	logic        fire;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_map_quality   <= 8'd30;
			cfg_q.min_base_quality  <= 8'd20;
			cfg_q.min_coverage      <= 16'd4;
			cfg_q.max_coverage      <= 16'd100;
			cfg_q.keep_chg_sites    <= 1'b0;
			cfg_q.keep_chh_sites    <= 1'b0;
			cfg_q.chromosome_length <= 32'hFFFF_FFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_MAP_QUALITY:   cfg_q.min_map_quality   <= cfg_data[7:0];
				CFG_MIN_BASE_QUALITY:  cfg_q.min_base_quality  <= cfg_data[7:0];
				CFG_MIN_COVERAGE:      cfg_q.min_coverage      <= cfg_data[15:0];
				CFG_MAX_COVERAGE:      cfg_q.max_coverage      <= cfg_data[15:0];
				CFG_KEEP_CHG_SITES:    cfg_q.keep_chg_sites    <= cfg_data[0];
				CFG_KEEP_CHH_SITES:    cfg_q.keep_chh_sites    <= cfg_data[0];
				CFG_CHROMOSOME_LENGTH: cfg_q.chromosome_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input register whenever the result register is free
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.command      <= command;
			item_s1.ref_pos      <= ref_pos;
			item_s1.read_base    <= read_base;
			item_s1.base_quality <= base_quality;
			item_s1.map_quality  <= map_quality;
			item_s1.read_flags   <= read_flags;
			item_s1.ref_before   <= ref_before;
			item_s1.ref_here     <= ref_here;
			item_s1.ref_after    <= ref_after;
		end
	end

	cmc_filter u_filter (
		.item      (item_s1),
		.cfg       (cfg_q),
		.floor_pos (floor_pos_q),
		.verdict   (verdict)
	);

	// Coverage check of the open site
	assign total  = {1'b0, meth_q} + {1'b0, unmeth_q};
	assign cov_ok = (site_q != 32'd0) &&
		(total >= {1'b0, cfg_q.min_coverage}) &&
		(total <= {1'b0, cfg_q.max_coverage});

	// Site tracking: a kept base at a new position closes the open site
	assign site_new = item_s1.ref_pos + 32'd1;
	assign opens    = verdict.keep && (site_q != site_new);
	assign emit     = (item_s1.command == CMD_END) ? cov_ok : (opens && cov_ok);

	assign meth_base   = opens ? 16'd0 : meth_q;
	assign unmeth_base = opens ? 16'd0 : unmeth_q;

	// Update the site state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_q      <= '0;
			meth_q      <= '0;
			unmeth_q    <= '0;
			ctx_q       <= CTX_NONE;
			tnc_q       <= '0;
			floor_pos_q <= '0;
		end else if (fire) begin
			if (item_s1.command == CMD_END) begin
				site_q      <= '0;
				meth_q      <= '0;
				unmeth_q    <= '0;
				ctx_q       <= CTX_NONE;
				tnc_q       <= '0;
				floor_pos_q <= '0;
			end else if (verdict.keep) begin
				if (opens) begin
					site_q <= site_new;
					ctx_q  <= verdict.ctx;
					tnc_q  <= verdict.tnc;
				end
				if (item_s1.read_base == NT16_C && meth_base != COUNT_MAX) begin
					meth_q <= meth_base + 16'd1;
				end else begin
					meth_q <= meth_base;
				end
				if (item_s1.read_base == NT16_T && unmeth_base != COUNT_MAX) begin
					unmeth_q <= unmeth_base + 16'd1;
				end else begin
					unmeth_q <= unmeth_base;
				end
				floor_pos_q <= item_s1.ref_pos;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			site_position      <= site_q;
			methylated_count   <= meth_q;
			unmethylated_count <= unmeth_q;
			site_context       <= ctx_q;
			trinucleotide_code <= tnc_q;
		end
	end

	// The input stalls only while an item waits in the input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// An end command leaves no open site behind
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.command == CMD_END) |=> (site_q == 32'd0 && floor_pos_q == 32'd0))
		else $error("site state not cleared after end command");

	// A result never names the empty site
	a_no_empty_site: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (site_position != 32'd0))
		else $error("result emitted for no open site");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import cmc_pkg::*;

	// One emitted cytosine site record
	typedef struct packed {
		logic [31:0] pos;
		logic [15:0] meth;
		logic [15:0] unmeth;
		logic [1:0]  ctx;
		logic [7:0]  tnc;
	} site_rec_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   command = CMD_BASE;
	logic [31:0]            ref_pos = '0;
	logic [3:0]             read_base = '0;
	logic [7:0]             base_quality = '0;
	logic [7:0]             map_quality = '0;
	logic [11:0]            read_flags = '0;
	logic [7:0]             ref_before = '0;
	logic [7:0]             ref_here = '0;
	logic [7:0]             ref_after = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [31:0]            site_position;
	logic [15:0]            methylated_count;
	logic [15:0]            unmethylated_count;
	logic [1:0]             site_context;
	logic [7:0]             trinucleotide_code;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	cytosine_methylation_counter_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.ref_pos           (ref_pos),
		.read_base         (read_base),
		.base_quality      (base_quality),
		.map_quality       (map_quality),
		.read_flags        (read_flags),
		.ref_before        (ref_before),
		.ref_here          (ref_here),
		.ref_after         (ref_after),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.site_position     (site_position),
		.methylated_count  (methylated_count),
		.unmethylated_count(unmethylated_count),
		.site_context      (site_context),
		.trinucleotide_code(trinucleotide_code),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// Predicted block state and register copy
	cfg_t        cfg_m;
	logic [31:0] open_site;
	logic [31:0] floor_pos;
	logic [15:0] meth_cnt;
	logic [15:0] unmeth_cnt;
	logic [1:0]  open_ctx;
	logic [7:0]  open_tnc;
	site_rec_t   pending_sites[$];

	int errors = 0;
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;
	int hold_req = 0;
	int hold_len = 0;

	always #5 clk = ~clk;

	// Receiver stall: random, or a long counted hold-off on request
	always @(posedge clk) begin : stall_drive
		int hold_seen;
		int hold_left;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = hold_len;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_on) begin
			out_stall <= ($urandom_range(99) < 18);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
	endtask

	// Compare each accepted result with the oldest predicted site
	always @(posedge clk) begin : result_check
		site_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sites.size() == 0) begin
				report("unexpected record, site_position", 32'd0, site_position);
			end else begin
				want = pending_sites.pop_front();
				if (site_position !== want.pos)
					report("site_position", want.pos, site_position);
				if (methylated_count !== want.meth)
					report("methylated_count", 32'(want.meth), 32'(methylated_count));
				if (unmethylated_count !== want.unmeth)
					report("unmethylated_count", 32'(want.unmeth),
						32'(unmethylated_count));
				if (site_context !== want.ctx)
					report("site_context", 32'(want.ctx), 32'(site_context));
				if (trinucleotide_code !== want.tnc)
					report("trinucleotide_code", 32'(want.tnc), 32'(trinucleotide_code));
			end
		end
	end

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		if (c >= CH_LOW_A && c <= CH_LOW_Z)
			return c - CASE_GAP;
		return c;
	endfunction

	function automatic logic [2:0] base_code(input logic [7:0] c);
		logic [2:0] n;
		if (c == CH_A)
			n = NUC_A;
		else if (c == CH_C)
			n = NUC_C;
		else if (c == CH_G)
			n = NUC_G;
		else if (c == CH_T)
			n = NUC_T;
		else
			n = NUC_OTHER;
		return n;
	endfunction

	function automatic bit is_act(input logic [7:0] c);
		return c == CH_A || c == CH_C || c == CH_T;
	endfunction

	task automatic clear_sites();
		open_site = '0;
		floor_pos = '0;
		meth_cnt = '0;
		unmeth_cnt = '0;
		open_ctx = CTX_NONE;
		open_tnc = '0;
	endtask

	// Queue the open site if it exists and its coverage is inside the limits
	task automatic close_site();
		logic [16:0] total;
		site_rec_t rec;
		total = {1'b0, meth_cnt} + {1'b0, unmeth_cnt};
		if (open_site != 0 && total >= {1'b0, cfg_m.min_coverage} &&
				total <= {1'b0, cfg_m.max_coverage}) begin
			rec.pos = open_site;
			rec.meth = meth_cnt;
			rec.unmeth = unmeth_cnt;
			rec.ctx = open_ctx;
			rec.tnc = open_tnc;
			pending_sites.push_back(rec);
		end
	endtask

	// Filter, classify and count one accepted item
	task automatic count_read(input item_t it);
		logic [7:0]  b;
		logic [7:0]  h;
		logic [7:0]  a;
		logic [2:0]  nb;
		logic [1:0]  ctx;
		logic [7:0]  tnc;
		logic [31:0] site;
		bit          kept;
		if (it.command == CMD_END) begin
			close_site();
			clear_sites();
			return;
		end
		if ((it.read_flags & FLAG_DROP_MASK) != 0)
			return;
		if (it.map_quality < cfg_m.min_map_quality)
			return;
		if (it.ref_pos < floor_pos)
			return;
		if (it.base_quality < cfg_m.min_base_quality)
			return;
		if (it.ref_pos == 0 ||
				{1'b0, it.ref_pos} + 33'd1 >= {1'b0, cfg_m.chromosome_length}) begin
			ctx = CTX_CHH;
			tnc = TNC_EDGE;
		end else begin
			b = to_upper(it.ref_before);
			h = to_upper(it.ref_here);
			a = to_upper(it.ref_after);
			nb = base_code(b);
			tnc = {nb[1:0], base_code(h), base_code(a)};
			if (h != CH_C)
				return;
			if (a == CH_G)
				ctx = CTX_CPG;
			else if (is_act(a))
				ctx = is_act(b) ? CTX_CHH : CTX_CHG;
			else
				ctx = (is_act(b) || b == CH_N) ? CTX_CHH : CTX_CHG;
		end
		if (ctx == CTX_CPG)
			kept = 1'b1;
		else if (ctx == CTX_CHG)
			kept = cfg_m.keep_chg_sites;
		else
			kept = cfg_m.keep_chh_sites;
		if (!kept)
			return;
		// Last position wraps to site zero, which is never emitted
		site = it.ref_pos + 32'd1;
		if (open_site != site) begin
			close_site();
			open_site = site;
			meth_cnt = '0;
			unmeth_cnt = '0;
			open_ctx = ctx;
			open_tnc = tnc;
		end
		if (it.read_base == NT16_C) begin
			if (meth_cnt != COUNT_MAX)
				meth_cnt++;
		end else if (it.read_base == NT16_T) begin
			if (unmeth_cnt != COUNT_MAX)
				unmeth_cnt++;
		end
		floor_pos = it.ref_pos;
	endtask

	// Offer one item, hold it until accepted, then predict
	task automatic send_item(input item_t it);
		while (gaps_on && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= it.command;
		ref_pos <= it.ref_pos;
		read_base <= it.read_base;
		base_quality <= it.base_quality;
		map_quality <= it.map_quality;
		read_flags <= it.read_flags;
		ref_before <= it.ref_before;
		ref_here <= it.ref_here;
		ref_after <= it.ref_after;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		count_read(it);
	endtask

	// Drop valid and wait for every predicted record, then let the pipe empty
	task automatic settle();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (pending_sites.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6)
			@(posedge clk);
	endtask

	// Write one register; unused upper data bits carry noise
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] data;
		case (idx) inside
			CFG_MIN_MAP_QUALITY, CFG_MIN_BASE_QUALITY: mask = 32'h0000_00FF;
			CFG_MIN_COVERAGE, CFG_MAX_COVERAGE:        mask = 32'h0000_FFFF;
			CFG_KEEP_CHG_SITES, CFG_KEEP_CHH_SITES:    mask = 32'h0000_0001;
			default:                                   mask = 32'hFFFF_FFFF;
		endcase
		data = ($urandom & ~mask) | (value & mask);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_MIN_MAP_QUALITY:   cfg_m.min_map_quality = data[7:0];
			CFG_MIN_BASE_QUALITY:  cfg_m.min_base_quality = data[7:0];
			CFG_MIN_COVERAGE:      cfg_m.min_coverage = data[15:0];
			CFG_MAX_COVERAGE:      cfg_m.max_coverage = data[15:0];
			CFG_KEEP_CHG_SITES:    cfg_m.keep_chg_sites = data[0];
			CFG_KEEP_CHH_SITES:    cfg_m.keep_chh_sites = data[0];
			CFG_CHROMOSOME_LENGTH: cfg_m.chromosome_length = data;
			default: ;
		endcase
	endtask

	task automatic load_config(input cfg_t c);
		settle();
		write_reg(CFG_MIN_MAP_QUALITY, {24'd0, c.min_map_quality});
		write_reg(CFG_MIN_BASE_QUALITY, {24'd0, c.min_base_quality});
		write_reg(CFG_MIN_COVERAGE, {16'd0, c.min_coverage});
		write_reg(CFG_MAX_COVERAGE, {16'd0, c.max_coverage});
		write_reg(CFG_KEEP_CHG_SITES, {31'd0, c.keep_chg_sites});
		write_reg(CFG_KEEP_CHH_SITES, {31'd0, c.keep_chh_sites});
		write_reg(CFG_CHROMOSOME_LENGTH, c.chromosome_length);
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t open_config(input logic [31:0] len);
		cfg_t c;
		c.min_map_quality = 8'd30;
		c.min_base_quality = 8'd20;
		c.min_coverage = 16'd1;
		c.max_coverage = 16'hFFFF;
		c.keep_chg_sites = 1'b1;
		c.keep_chh_sites = 1'b1;
		c.chromosome_length = len;
		return c;
	endfunction

	function automatic item_t base_item(input logic [31:0] pos, input logic [3:0] rb,
			input logic [7:0] b, input logic [7:0] h, input logic [7:0] a);
		item_t it;
		it.command = CMD_BASE;
		it.ref_pos = pos;
		it.read_base = rb;
		it.base_quality = 8'hFF;
		it.map_quality = 8'hFF;
		it.read_flags = '0;
		it.ref_before = b;
		it.ref_here = h;
		it.ref_after = a;
		return it;
	endfunction

	// End command with junk in every other field
	function automatic item_t end_item();
		item_t it;
		it.command = CMD_END;
		it.ref_pos = $urandom;
		it.read_base = 4'($urandom_range(15));
		it.base_quality = 8'($urandom_range(255));
		it.map_quality = 8'($urandom_range(255));
		it.read_flags = 12'($urandom_range(4095));
		it.ref_before = 8'($urandom_range(255));
		it.ref_here = 8'($urandom_range(255));
		it.ref_after = 8'($urandom_range(255));
		return it;
	endfunction

	function automatic logic [7:0] ref_char();
		logic [7:0] c;
		case ($urandom_range(15)) inside
			0, 1:    c = CH_A;
			2, 3:    c = CH_C;
			4, 5:    c = CH_G;
			6, 7:    c = CH_T;
			8:       c = CH_N;
			9:       c = CH_A + CASE_GAP;
			10:      c = CH_C + CASE_GAP;
			11:      c = CH_G + CASE_GAP;
			12:      c = CH_T + CASE_GAP;
			13:      c = CH_N + CASE_GAP;
			default: c = 8'($urandom_range(255));
		endcase
		return c;
	endfunction

	// Mostly passing base at pos with random content
	function automatic item_t stream_item(input logic [31:0] pos);
		item_t it;
		int r;
		it.command = CMD_BASE;
		it.ref_pos = pos;
		r = $urandom_range(99);
		if (r < 45)
			it.read_base = NT16_C;
		else if (r < 80)
			it.read_base = NT16_T;
		else
			it.read_base = 4'($urandom_range(15));
		if ($urandom_range(9) == 0)
			it.map_quality = 8'($urandom_range(255));
		else
			it.map_quality = 8'($urandom_range(255, cfg_m.min_map_quality));
		if ($urandom_range(9) == 0)
			it.base_quality = 8'($urandom_range(255));
		else
			it.base_quality = 8'($urandom_range(255, cfg_m.min_base_quality));
		if ($urandom_range(9) == 0)
			it.read_flags = 12'($urandom_range(4095));
		else
			it.read_flags = 12'($urandom_range(255));
		it.ref_before = ref_char();
		r = $urandom_range(99);
		if (r < 70)
			it.ref_here = CH_C;
		else if (r < 82)
			it.ref_here = CH_C + CASE_GAP;
		else
			it.ref_here = ref_char();
		it.ref_after = ref_char();
		return it;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it = end_item();
		it.command = ($urandom_range(9) == 0) ? CMD_END : CMD_BASE;
		return it;
	endfunction

	// One stream: runs of reads per site, forward steps, stray backward reads, noise and end items
	task automatic random_stream(input int count, input logic [31:0] start);
		item_t       it;
		logic [31:0] cur;
		logic [31:0] pos;
		logic [31:0] step;
		int          r;
		cur = start;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 7) begin
				it = noise_item();
			end else if (r < 8) begin
				it = end_item();
			end else begin
				r = $urandom_range(99);
				pos = cur;
				if (r >= 60) begin
					step = $urandom_range(3, 1);
					cur = (cur > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : cur + step;
					pos = cur;
				end else if (r >= 55 && cur > 3) begin
					pos = cur - $urandom_range(3, 1);
				end
				it = stream_item(pos);
			end
			send_item(it);
		end
		send_item(end_item());
	endtask

	function automatic cfg_t random_config(input logic [31:0] start);
		cfg_t c;
		c.min_map_quality = 8'($urandom_range(60));
		c.min_base_quality = 8'($urandom_range(60));
		c.min_coverage = 16'($urandom_range(4, 1));
		if ($urandom_range(99) < 70)
			c.max_coverage = 16'($urandom_range(65535, 4));
		else
			c.max_coverage = 16'($urandom_range(6, 1));
		c.keep_chg_sites = 1'($urandom_range(1));
		c.keep_chh_sites = 1'($urandom_range(1));
		case ($urandom_range(2))
			0:       c.chromosome_length = 32'hFFFF_FFFF;
			1:       c.chromosome_length = start + $urandom_range(300, 20);
			default: c.chromosome_length = $urandom;
		endcase
		return c;
	endfunction

	// Each filter and each context once, edges, lowercase, last position
	task automatic test_filters_and_contexts();
		item_t it;
		load_config(open_config(32'd1000));
		send_item(end_item());
		send_item(base_item(32'd0, NT16_C, CH_G, CH_A, CH_T));
		send_item(base_item(32'd5, NT16_C, CH_A, CH_C, CH_G));
		send_item(base_item(32'd5, NT16_T, CH_A + CASE_GAP, CH_C + CASE_GAP, CH_G + CASE_GAP));
		it = base_item(32'd5, NT16_C, CH_A, CH_C, CH_G);
		it.read_flags = 12'h100;
		send_item(it);
		it.read_flags = 12'h800;
		send_item(it);
		it.read_flags = 12'h0FF;
		send_item(it);
		it.map_quality = 8'd29;
		send_item(it);
		it.map_quality = 8'd30;
		it.base_quality = 8'd19;
		send_item(it);
		it.base_quality = 8'd20;
		send_item(it);
		send_item(base_item(32'd4, NT16_C, CH_A, CH_C, CH_G));
		send_item(base_item(32'd5, 4'hF, CH_A, CH_C, CH_G));
		send_item(base_item(32'd6, NT16_C, CH_C, CH_A, CH_G));
		send_item(base_item(32'd7, NT16_C, CH_C, CH_C, CH_A));
		send_item(base_item(32'd8, NT16_T, CH_G, CH_C, CH_A));
		send_item(base_item(32'd9, NT16_C, CH_N, CH_C, CH_N));
		send_item(base_item(32'd10, NT16_C, CH_G, CH_C, CH_N));
		send_item(base_item(32'd11, NT16_T, 8'h58, CH_C, 8'h78));
		send_item(base_item(32'd999, NT16_C, CH_A, CH_G, CH_A));
		send_item(end_item());
		send_item(base_item(32'hFFFF_FFFF, NT16_C, CH_A, CH_C, CH_G));
		send_item(end_item());
	endtask

	// Coverage window edges, inverted window, quality thresholds at the top
	task automatic test_coverage_limits();
		cfg_t  c;
		item_t it;
		c = open_config(32'hFFFF_FFFF);
		c.min_map_quality = 8'hFF;
		c.min_base_quality = 8'hFF;
		c.min_coverage = 16'd3;
		c.max_coverage = 16'd2;
		c.keep_chg_sites = 1'b0;
		c.keep_chh_sites = 1'b0;
		load_config(c);
		repeat (3)
			send_item(base_item(32'd20, NT16_C, CH_A, CH_C, CH_G));
		it = base_item(32'd20, NT16_C, CH_A, CH_C, CH_G);
		it.map_quality = 8'hFE;
		send_item(it);
		it.map_quality = 8'hFF;
		it.base_quality = 8'hFE;
		send_item(it);
		send_item(end_item());
		c.min_map_quality = 8'd0;
		c.min_base_quality = 8'd0;
		c.min_coverage = 16'd2;
		c.max_coverage = 16'd3;
		load_config(c);
		send_item(base_item(32'd30, NT16_C, CH_A, CH_C, CH_G));
		repeat (2)
			send_item(base_item(32'd31, NT16_T, CH_T, CH_C, CH_G));
		repeat (4)
			send_item(base_item(32'd32, NT16_C, CH_C, CH_C, CH_G));
		send_item(base_item(32'd33, NT16_C, CH_A, CH_C, CH_A));
		send_item(base_item(32'd34, NT16_C, CH_G, CH_C, CH_A));
		send_item(base_item(32'd35, NT16_T, CH_A, CH_C, CH_G));
		send_item(end_item());
	endtask

	// Long run with no idling on either side, deep counts at two sites
	task automatic test_back_to_back();
		load_config(open_config(32'hFFFF_FFFF));
		gaps_on = 1'b0;
		stall_on = 1'b0;
		repeat (60)
			send_item(base_item(32'd100, NT16_C, CH_A, CH_C, CH_G));
		repeat (60)
			send_item(base_item(32'd101, NT16_T, CH_A, CH_C, CH_G));
		send_item(base_item(32'd102, NT16_C, CH_A, CH_C, CH_G));
		send_item(end_item());
		gaps_on = 1'b1;
		stall_on = 1'b1;
	endtask

	// Hold the receiver off while every item opens a new site
	task automatic test_backpressure();
		load_config(open_config(32'hFFFF_FFFF));
		gaps_on = 1'b0;
		stall_on = 1'b0;
		hold_len = 300;
		hold_req++;
		for (int i = 0; i < 60; i++)
			send_item(base_item(32'd200 + i, NT16_C, CH_A, CH_C, CH_G));
		send_item(end_item());
		gaps_on = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_random_streams();
		cfg_t        c;
		logic [31:0] start;
		c = open_config(32'hFFFF_FFFF);
		c.min_map_quality = 8'd0;
		c.min_base_quality = 8'd0;
		load_config(c);
		random_stream(288, 32'd0);
		c.min_map_quality = 8'hFF;
		c.min_base_quality = 8'hFF;
		c.min_coverage = 16'd1;
		c.max_coverage = 16'd1;
		c.keep_chg_sites = 1'b0;
		c.chromosome_length = 32'd0;
		load_config(c);
		random_stream(288, 32'd50);
		for (int p = 2; p < 6; p++) begin
			if (p == 4)
				start = 32'hFFFF_FF00 + $urandom_range(100);
			else if (p == 5)
				start = $urandom;
			else
				start = $urandom_range(1000);
			c = random_config(start);
			if (p == 4)
				c.chromosome_length = 32'hFFFF_FFFF;
			load_config(c);
			random_stream(288, start);
		end
	endtask

	initial begin
		cfg_m.min_map_quality = 8'd30;
		cfg_m.min_base_quality = 8'd20;
		cfg_m.min_coverage = 16'd4;
		cfg_m.max_coverage = 16'd100;
		cfg_m.keep_chg_sites = 1'b0;
		cfg_m.keep_chh_sites = 1'b0;
		cfg_m.chromosome_length = 32'hFFFF_FFFF;
		clear_sites();
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_filters_and_contexts();
		test_coverage_limits();
		test_back_to_back();
		test_backpressure();
		test_random_streams();
		settle();
		if (pending_sites.size() != 0)
			$display("%0t ns: %0d expected site records never arrived", $time,
				pending_sites.size());
		if (errors == 0 && pending_sites.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hard limit on run time
	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
